@@ src/trz_pkg.sv @@
// Shared constants, command and register codes, and the multiply-accumulate control type.
`timescale 1ns / 1ps
package trz_pkg;

  localparam int CoordW   = 16;
  localparam int ZW       = 24;
  localparam int RgbW     = 24;
  localparam int IdxW     = 16;
  localparam int CmdW     = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;
  localparam int SizeW    = 9;
  localparam int DiffW    = 17;
  localparam int DzW      = 25;
  localparam int DzLoW    = 12;
  localparam int RelW     = 19;
  localparam int MulAW    = 38;
  localparam int MulBW    = 18;
  localparam int ProdW    = MulAW + MulBW;
  localparam int AccW     = 64;
  localparam int DetW     = 36;
  localparam int NumW     = 66;
  localparam int DenW     = DetW + 1;
  localparam int QuotW    = 26;
  localparam int ZSumW    = 28;
  localparam int InDataW  = 208;
  localparam int OutDataW = 48;

  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CmdW-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_VIEW_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_VIEW_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEPTH_CULL  = 2'd2;

  localparam logic [RgbW-1:0]      GREY_COLOR = 24'h3C3C3C;
  localparam logic signed [ZW-1:0] DEPTH_MAX  = 24'sh7FFFFF;
  localparam logic signed [ZW-1:0] DEPTH_MIN  = -24'sh800000;

  // Control word that travels with a product into the accumulate stage.
  typedef struct packed {
    logic acc_en;  // accumulate the product in the following cycle
    logic first;   // start a fresh sum instead of adding to the old one
    logic neg;     // subtract the product
    logic shl;     // weight the product by 2^DzLoW
  } mac_ctrl_t;

endpackage

@@ src/triangle_raster_zbuffer.sv @@
// Top level: triangle rasteriser with colour and depth stores and its sequencer.
`timescale 1ns / 1ps
// Commands arrive on the slave stream: tuser carries the command (clear, draw,
// read) and tdata the triangle, colour and read address. Results leave on the
// master stream, one transaction per read command, nothing for clear or draw.
// The block takes one command at a time; s_axis_tready is high only while the
// sequencer is idle.
// After reset, and after every clear command, the stores are swept one entry
// a cycle, all MAX_WIDTH*MAX_HEIGHT entries (65536 by default), before the next
// command is taken. Configuration writes are taken at any time.
// A read of an address beyond the viewport area returns zero colour and depth.
// A draw first computes the determinant and the first row address on the
// shared multiplier, and then, unless the triangle has zero area, an empty box
// or is culled, visits every pixel of the clipped bounding box in turn. A pixel
// that fails an edge test is left early. Every product goes through the one
// shared multiplier, and the depth quotient through a bit-serial divider of
// 26 steps.
// A finished read result waits in the output register while the receiver
// stalls; the block still accepts the next command, and only a second read
// holds its result back until the first has been taken.
module triangle_raster_zbuffer import trz_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // cmd
  input  logic [CmdW-1:0]     s_axis_tuser_i,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz, color, pixel_index
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // pixel_color, pixel_depth
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int StoreDepth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(StoreDepth);
  localparam logic [AW-1:0] LastAddr = AW'(StoreDepth - 1);
  localparam logic [AW:0]   DepthVec = (AW + 1)'(StoreDepth);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_SMUL  = 4'd3;
  localparam logic [3:0] S_PIX   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_ZCMP  = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;

  // Configuration registers.
  logic [SizeW-1:0] view_width_q, view_height_q;
  logic             cull_en_q;
  logic [SizeW-1:0] w_eff, h_eff;

  // Sequencer.
  logic [3:0]    state_q;
  logic [3:0]    step_q;
  logic [AW-1:0] clr_cnt_q;

  // Command held for the whole of its work.
  logic [CmdW-1:0]          cmd_q;
  logic signed [CoordW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic signed [ZW-1:0]     az_q, bz_q, cz_q;
  logic [RgbW-1:0]          color_q;
  logic [IdxW-1:0]          pidx_q;

  // Triangle setup.
  logic signed [DiffW-1:0] ux_q, uy_q, vx_q, vy_q, exbc_q, eybc_q, exca_q, eyca_q;
  logic signed [DzW-1:0]   dzb_q, dzc_q;
  logic [SizeW-1:0]        x0_q, x1_q, y0_q, y1_q;
  logic                    skip_q;
  logic signed [DetW-1:0]  d_q;
  logic [AW-1:0]           row_q;
  logic [SizeW-1:0]        x_q, y_q;
  logic signed [MulAW-1:0] nb_q, ng_q;
  logic                    qneg_q;
  logic                    oob_q;

  // Output register.
  logic            out_valid_q;
  logic [RgbW-1:0] out_color_q;
  logic [ZW-1:0]   out_depth_q;

  // Stores.
  logic [RgbW-1:0] color_mem [StoreDepth];
  logic [ZW-1:0]   depth_mem [StoreDepth];
  logic [RgbW-1:0] rd_color_q;
  logic [ZW-1:0]   rd_depth_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   wr_addr, rd_addr, pix_addr;
  logic [RgbW-1:0] wr_color;
  logic [ZW-1:0]   wr_depth;

  // Shared arithmetic.
  logic signed [MulAW-1:0] mac_a;
  logic signed [MulBW-1:0] mac_b;
  mac_ctrl_t               mac_ctrl;
  logic signed [AccW-1:0]  acc;
  logic                    div_start, div_done;
  logic [QuotW-1:0]        quot;
  logic [AccW-1:0]         num_mag;
  logic [DetW-1:0]         d_mag;
  logic [NumW-1:0]         div_num;
  logic [DenW-1:0]         div_den;

  logic accept;
  logic advance;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);

  // A size of zero acts as one, a size beyond the store acts as its maximum.
  always_comb begin
    if (view_width_q == '0) begin
      w_eff = SizeW'(1);
    end else if (int'(view_width_q) > MAX_WIDTH) begin
      w_eff = SizeW'(MAX_WIDTH);
    end else begin
      w_eff = view_width_q;
    end
    if (view_height_q == '0) begin
      h_eff = SizeW'(1);
    end else if (int'(view_height_q) > MAX_HEIGHT) begin
      h_eff = SizeW'(MAX_HEIGHT);
    end else begin
      h_eff = view_height_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_width_q  <= SizeW'(256);
      view_height_q <= SizeW'(256);
      cull_en_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_VIEW_WIDTH:  view_width_q  <= cfg_data_i;
        CFG_VIEW_HEIGHT: view_height_q <= cfg_data_i;
        CFG_DEPTH_CULL:  cull_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Bounding box: floor of the minimum clipped at zero, ceiling of the
  // maximum clipped at size-1, upper bound exclusive.
  logic signed [CoordW-1:0] min_x, min_y, max_x, max_y;
  logic signed [16:0]       fl_x, fl_y, cl_x, cl_y, lim_x, lim_y, bx0, bx1, by0, by1;

  always_comb begin
    min_x = (ax_q < bx_q) ? ax_q : bx_q;
    min_x = (min_x < cx_q) ? min_x : cx_q;
    min_y = (ay_q < by_q) ? ay_q : by_q;
    min_y = (min_y < cy_q) ? min_y : cy_q;
    max_x = (ax_q > bx_q) ? ax_q : bx_q;
    max_x = (max_x > cx_q) ? max_x : cx_q;
    max_y = (ay_q > by_q) ? ay_q : by_q;
    max_y = (max_y > cy_q) ? max_y : cy_q;
    fl_x  = 17'(min_x) >>> 4;
    fl_y  = 17'(min_y) >>> 4;
    cl_x  = (17'(max_x) + 17'sd15) >>> 4;
    cl_y  = (17'(max_y) + 17'sd15) >>> 4;
    lim_x = $signed({8'b0, w_eff}) - 17'sd1;
    lim_y = $signed({8'b0, h_eff}) - 17'sd1;
    bx0   = (fl_x < 17'sd0) ? 17'sd0 : fl_x;
    by0   = (fl_y < 17'sd0) ? 17'sd0 : fl_y;
    bx1   = (cl_x > lim_x) ? lim_x : cl_x;
    by1   = (cl_y > lim_y) ? lim_y : cl_y;
  end

  // Operands of the shared multiplier. Edge tests use the pixel centre,
  // depth interpolation the pixel corner.
  logic                    centre, sel_b, sel_c;
  logic signed [RelW-1:0]  pt_x, pt_y, vtx_x, vtx_y, rel_x, rel_y;
  logic signed [10:0]      rows_below;

  assign centre = (step_q < 4'd6);
  assign sel_b  = (step_q == 4'd2) || (step_q == 4'd3);
  assign sel_c  = (step_q == 4'd4) || (step_q == 4'd5);
  assign pt_x   = $signed(RelW'({x_q, centre, 3'b000}));
  assign pt_y   = $signed(RelW'({y_q, centre, 3'b000}));
  assign vtx_x  = sel_b ? RelW'(bx_q) : (sel_c ? RelW'(cx_q) : RelW'(ax_q));
  assign vtx_y  = sel_b ? RelW'(by_q) : (sel_c ? RelW'(cy_q) : RelW'(ay_q));
  assign rel_x  = pt_x - vtx_x;
  assign rel_y  = pt_y - vtx_y;
  assign rows_below = $signed({2'b0, h_eff}) - 11'sd1 - $signed({2'b0, y0_q});

  always_comb begin
    mac_a    = '0;
    mac_b    = '0;
    mac_ctrl = '0;
    case (state_q)
      S_SMUL: begin
        case (step_q)
          4'd0: begin
            mac_a    = MulAW'(ux_q);
            mac_b    = MulBW'(vy_q);
            mac_ctrl = '{acc_en: 1'b1, first: 1'b1, neg: 1'b0, shl: 1'b0};
          end
          4'd1: begin
            mac_a    = MulAW'(uy_q);
            mac_b    = MulBW'(vx_q);
            mac_ctrl = '{acc_en: 1'b1, first: 1'b0, neg: 1'b1, shl: 1'b0};
          end
          4'd2: begin
            mac_a    = MulAW'(rows_below);
            mac_b    = $signed(MulBW'(w_eff));
            mac_ctrl = '{acc_en: 1'b1, first: 1'b1, neg: 1'b0, shl: 1'b0};
          end
          default: ;
        endcase
      end
      S_PIX: begin
        case (step_q)
          4'd0, 4'd2, 4'd4: begin
            mac_a    = MulAW'(rel_x);
            mac_b    = (step_q == 4'd0) ? MulBW'(uy_q) :
                       (step_q == 4'd2) ? MulBW'(eybc_q) : MulBW'(eyca_q);
            mac_ctrl = '{acc_en: 1'b1, first: 1'b1, neg: 1'b1, shl: 1'b0};
          end
          4'd1, 4'd3, 4'd5: begin
            mac_a    = MulAW'(rel_y);
            mac_b    = (step_q == 4'd1) ? MulBW'(ux_q) :
                       (step_q == 4'd3) ? MulBW'(exbc_q) : MulBW'(exca_q);
            mac_ctrl = '{acc_en: 1'b1, first: 1'b0, neg: 1'b0, shl: 1'b0};
          end
          4'd6: begin
            mac_a    = MulAW'(rel_x);
            mac_b    = MulBW'(vy_q);
            mac_ctrl = '{acc_en: 1'b1, first: 1'b1, neg: 1'b0, shl: 1'b0};
          end
          4'd7: begin
            mac_a    = MulAW'(rel_y);
            mac_b    = MulBW'(vx_q);
            mac_ctrl = '{acc_en: 1'b1, first: 1'b0, neg: 1'b1, shl: 1'b0};
          end
          4'd8: begin
            mac_a    = MulAW'(rel_y);
            mac_b    = MulBW'(ux_q);
            mac_ctrl = '{acc_en: 1'b1, first: 1'b1, neg: 1'b0, shl: 1'b0};
          end
          4'd9: begin
            mac_a    = MulAW'(rel_x);
            mac_b    = MulBW'(uy_q);
            mac_ctrl = '{acc_en: 1'b1, first: 1'b0, neg: 1'b1, shl: 1'b0};
          end
          // The depth deltas are split into a signed upper part and an
          // unsigned lower part so that each fits the multiplier.
          4'd10: begin
            mac_a    = nb_q;
            mac_b    = MulBW'(dzb_q >>> DzLoW);
            mac_ctrl = '{acc_en: 1'b1, first: 1'b1, neg: 1'b0, shl: 1'b1};
          end
          4'd11: begin
            mac_a    = nb_q;
            mac_b    = $signed(MulBW'(dzb_q[DzLoW-1:0]));
            mac_ctrl = '{acc_en: 1'b1, first: 1'b0, neg: 1'b0, shl: 1'b0};
          end
          4'd12: begin
            mac_a    = ng_q;
            mac_b    = MulBW'(dzc_q >>> DzLoW);
            mac_ctrl = '{acc_en: 1'b1, first: 1'b0, neg: 1'b0, shl: 1'b1};
          end
          4'd13: begin
            mac_a    = ng_q;
            mac_b    = $signed(MulBW'(dzc_q[DzLoW-1:0]));
            mac_ctrl = '{acc_en: 1'b1, first: 1'b0, neg: 1'b0, shl: 1'b0};
          end
          default: ;
        endcase
      end
      S_RD: begin
        if (step_q == 4'd0) begin
          mac_a    = $signed(MulAW'(w_eff));
          mac_b    = $signed(MulBW'(h_eff));
          mac_ctrl = '{acc_en: 1'b1, first: 1'b1, neg: 1'b0, shl: 1'b0};
        end
      end
      default: ;
    endcase
  end

  trz_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .ctrl_i (mac_ctrl),
    .acc_o  (acc)
  );

  // Rounded quotient: (2|num| + |d|) / (2|d|), sign applied afterwards.
  assign num_mag   = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
  assign d_mag     = d_q[DetW-1] ? DetW'(-d_q) : DetW'(d_q);
  assign div_num   = NumW'({num_mag, 1'b0}) + NumW'(d_mag);
  assign div_den   = {d_mag, 1'b0};
  assign div_start = (state_q == S_PIX) && (step_q == 4'd15);

  trz_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Interpolated depth, saturated to the store's range.
  logic signed [ZSumW-1:0] qsig, zsum;
  logic signed [ZW-1:0]    z_sat;

  always_comb begin
    qsig = $signed(ZSumW'(quot));
    zsum = ZSumW'(az_q) + (qneg_q ? -qsig : qsig);
    if (zsum > ZSumW'(DEPTH_MAX)) begin
      z_sat = DEPTH_MAX;
    end else if (zsum < ZSumW'(DEPTH_MIN)) begin
      z_sat = DEPTH_MIN;
    end else begin
      z_sat = zsum[ZW-1:0];
    end
  end

  // Store rows run top down while window y runs bottom up.
  assign pix_addr = row_q + AW'(x_q);

  logic oob_now;
  assign oob_now = ($unsigned(acc) <= AccW'(pidx_q)) ||
                   ({16'b0, pidx_q} >= 32'(StoreDepth));

  always_comb begin
    mem_we   = 1'b0;
    wr_addr  = pix_addr;
    wr_color = color_q;
    wr_depth = z_sat;
    if (state_q == S_CLR) begin
      mem_we   = 1'b1;
      wr_addr  = clr_cnt_q;
      wr_color = GREY_COLOR;
      wr_depth = DEPTH_MAX;
    end else if (state_q == S_ZCMP) begin
      mem_we = (z_sat < $signed(rd_depth_q));
    end
  end

  assign mem_re  = ((state_q == S_PIX) && (step_q == 4'd0)) ||
                   ((state_q == S_RD) && (step_q == 4'd2) && !oob_now);
  assign rd_addr = (state_q == S_RD) ? AW'(pidx_q) : pix_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      color_mem[wr_addr] <= wr_color;
      depth_mem[wr_addr] <= wr_depth;
    end
    if (mem_re) begin
      rd_color_q <= color_mem[rd_addr];
      rd_depth_q <= depth_mem[rd_addr];
    end
  end

  // Move on to the next pixel of the box, or finish the triangle.
  logic last_x, last_y;
  assign last_x = (10'(x_q) + 10'd1) >= 10'(x1_q);
  assign last_y = (10'(y_q) + 10'd1) >= 10'(y1_q);

  always_comb begin
    advance = 1'b0;
    case (state_q)
      S_PIX: begin
        advance = ((step_q == 4'd3) || (step_q == 4'd5) || (step_q == 4'd7)) &&
                  acc[AccW-1];
      end
      S_ZCMP: advance = 1'b1;
      default: ;
    endcase
  end

  logic rd_out_ok;
  assign rd_out_ok = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      step_q      <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == LastAddr) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            step_q    <= '0;
            clr_cnt_q <= '0;
            case (s_axis_tuser_i)
              CMD_CLEAR: state_q <= S_CLR;
              CMD_DRAW:  state_q <= S_SETUP;
              CMD_READ:  state_q <= S_RD;
              default:   state_q <= S_IDLE;
            endcase
          end
        end
        S_SETUP: begin
          step_q  <= '0;
          state_q <= S_SMUL;
        end
        S_SMUL: begin
          step_q <= step_q + 1'b1;
          if (step_q == 4'd4) begin
            step_q  <= '0;
            state_q <= (d_q == '0 || skip_q) ? S_IDLE : S_PIX;
          end
        end
        S_PIX: begin
          step_q <= step_q + 1'b1;
          if (step_q == 4'd15) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_ZCMP;
          end
        end
        S_RD: begin
          if (step_q != 4'd3) begin
            step_q <= step_q + 1'b1;
          end else if (rd_out_ok) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (advance) begin
        step_q <= '0;
        if (last_x && last_y) begin
          state_q <= S_IDLE;
        end else begin
          state_q <= S_PIX;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= s_axis_tuser_i;
      ax_q    <= s_axis_tdata_i[15:0];
      ay_q    <= s_axis_tdata_i[31:16];
      az_q    <= s_axis_tdata_i[55:32];
      bx_q    <= s_axis_tdata_i[71:56];
      by_q    <= s_axis_tdata_i[87:72];
      bz_q    <= s_axis_tdata_i[111:88];
      cx_q    <= s_axis_tdata_i[127:112];
      cy_q    <= s_axis_tdata_i[143:128];
      cz_q    <= s_axis_tdata_i[167:144];
      color_q <= s_axis_tdata_i[191:168];
      pidx_q  <= s_axis_tdata_i[207:192];
    end
    if (state_q == S_SETUP) begin
      ux_q   <= DiffW'(bx_q) - DiffW'(ax_q);
      uy_q   <= DiffW'(by_q) - DiffW'(ay_q);
      vx_q   <= DiffW'(cx_q) - DiffW'(ax_q);
      vy_q   <= DiffW'(cy_q) - DiffW'(ay_q);
      exbc_q <= DiffW'(cx_q) - DiffW'(bx_q);
      eybc_q <= DiffW'(cy_q) - DiffW'(by_q);
      exca_q <= DiffW'(ax_q) - DiffW'(cx_q);
      eyca_q <= DiffW'(ay_q) - DiffW'(cy_q);
      dzb_q  <= DzW'(bz_q) - DzW'(az_q);
      dzc_q  <= DzW'(cz_q) - DzW'(az_q);
      x0_q   <= bx0[SizeW-1:0];
      x1_q   <= bx1[SizeW-1:0];
      y0_q   <= by0[SizeW-1:0];
      y1_q   <= by1[SizeW-1:0];
      skip_q <= (bx0 >= bx1) || (by0 >= by1) ||
                (cull_en_q && (az_q[ZW-1] || bz_q[ZW-1] || cz_q[ZW-1]));
    end
    if (state_q == S_SMUL && step_q == 4'd3) begin
      d_q <= acc[DetW-1:0];
    end
    if (state_q == S_SMUL && step_q == 4'd4) begin
      row_q <= acc[AW-1:0];
      x_q   <= x0_q;
      y_q   <= y0_q;
    end
    if (state_q == S_PIX && step_q == 4'd9) begin
      nb_q <= acc[MulAW-1:0];
    end
    if (state_q == S_PIX && step_q == 4'd11) begin
      ng_q <= acc[MulAW-1:0];
    end
    if (div_start) begin
      qneg_q <= acc[AccW-1] ^ d_q[DetW-1];
    end
    if (advance) begin
      if (!last_x) begin
        x_q <= x_q + 1'b1;
      end else if (!last_y) begin
        x_q   <= x0_q;
        y_q   <= y_q + 1'b1;
        row_q <= row_q - AW'(w_eff);
      end
    end
    if (state_q == S_RD && step_q == 4'd2) begin
      oob_q <= oob_now;
    end
    if (state_q == S_RD && step_q == 4'd3 && rd_out_ok && cmd_q == CMD_READ) begin
      out_color_q <= oob_q ? '0 : rd_color_q;
      out_depth_q <= oob_q ? '0 : rd_depth_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_depth_q, out_color_q};

  // Every store write lands inside the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, wr_addr} < DepthVec))
    else $error("store write beyond the last entry");

  // A result only appears as the last step of a read command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_RD))
    else $error("result raised outside a read");

  // The pixel walk stays inside the clipped box.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PIX) |-> ((x_q < x1_q) && (y_q < y1_q)))
    else $error("pixel walk left the bounding box");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside its wait state");

endmodule

@@ src/trz_mac.sv @@
// Shared signed multiplier with a product register and a 64-bit accumulator.
`timescale 1ns / 1ps
module trz_mac import trz_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [MulAW-1:0] a_i,
  input  logic signed [MulBW-1:0] b_i,
  input  mac_ctrl_t               ctrl_i,
  output logic signed [AccW-1:0]  acc_o
);

  logic signed [ProdW-1:0] prod_q;
  mac_ctrl_t               ctrl_q;
  logic signed [AccW-1:0]  acc_q, acc_d, term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    acc_q  <= acc_d;
  end

  always_comb begin
    term = AccW'(prod_q);
    if (ctrl_q.shl) begin
      term = term <<< DzLoW;
    end
    if (ctrl_q.neg) begin
      term = -term;
    end
    if (ctrl_q.acc_en) begin
      acc_d = (ctrl_q.first ? '0 : acc_q) + term;
    end else begin
      acc_d = acc_q;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ src/trz_div.sv @@
// Restoring divider, one quotient bit per cycle, with a saturating early exit.
`timescale 1ns / 1ps
module trz_div import trz_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  output logic             done_o,
  output logic [QuotW-1:0] quot_o
);

  localparam int CntW = $clog2(QuotW);

  logic [NumW-1:0]  rem_q, dsh_q;
  logic [QuotW-1:0] quot_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic             ovf, ge;

  // A quotient beyond the bit budget saturates the depth anyway.
  assign ovf = num_i >= (NumW'(den_i) << QuotW);
  assign ge  = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsh_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (ovf) begin
          quot_q <= '1;
          done_q <= 1'b1;
        end else begin
          rem_q  <= num_i;
          dsh_q  <= NumW'(den_i) << (QuotW - 1);
          cnt_q  <= CntW'(QuotW - 1);
          quot_q <= '0;
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (ge) begin
          rem_q <= rem_q - dsh_q;
        end
        quot_q <= {quot_q[QuotW-2:0], ge};
        dsh_q  <= dsh_q >> 1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ tb/sv/triangle_raster_zbuffer_tb.sv @@
// Testbench for the triangle rasteriser with colour and depth stores.
`timescale 1ns / 1ps
// Commands go in on the slave stream from a queue that the initial block fills
// phase by phase. The driver predicts each accepted transaction against its own
// copy of both stores and of the viewport registers. Every read pushes one
// expected pixel. The monitor takes results under random back-pressure,
// including one long hold-off, and checks colour and depth against the oldest
// expected pixel.
// Clears cost a full store sweep of 65536 entries, so there are only a handful.
// Covered pixels are slow, as each needs the bit-serial divider, so draws are small
// triangles, or fully random triangles that fall into a tiny viewport.
module triangle_raster_zbuffer_tb;
  import trz_pkg::*;

  localparam int StoreSize  = 256 * 256;
  localparam int CycleLimit = 4000000;
  localparam int ShownMax   = 10;

  typedef struct {
    logic [CmdW-1:0]          cmd;
    logic signed [CoordW-1:0] ax, ay, bx, byc, cx, cy;
    logic signed [ZW-1:0]     az, bz, cz;
    logic [RgbW-1:0]          color;
    logic [IdxW-1:0]          pidx;
  } raster_cmd_t;

  typedef struct {
    logic [RgbW-1:0] color;
    logic [ZW-1:0]   depth;
  } pixel_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [CmdW-1:0]     s_axis_tuser_i = '0;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  triangle_raster_zbuffer i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tuser_i,
    .s_axis_tdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .m_axis_tdata_o,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the block: registers and both stores.
  logic [SizeW-1:0] view_w_q = 9'd256;
  logic [SizeW-1:0] view_h_q = 9'd256;
  logic             cull_q = 1'b0;
  logic [RgbW-1:0]  colour_mem [StoreSize];
  int               depth_mem [StoreSize];

  raster_cmd_t cmd_q [$];
  pixel_t      pixel_q [$];
  int          n_errors = 0;
  int          n_shown = 0;
  int          hold_cycles = 0;
  int          last_px = 0;
  int          last_py = 0;

  function automatic longint size_eff(logic [SizeW-1:0] v);
    if (v == 0) return 1;
    return (v > 256) ? 256 : longint'(v);
  endfunction

  function automatic bit edge_inside(longint x0, longint y0, longint x1, longint y1,
                                     longint px, longint py);
    return (-(y1 - y0) * (px - x0) + (x1 - x0) * (py - y0)) >= 0;
  endfunction

  // Rounds to nearest with ties away from zero; den is positive.
  function automatic longint div_nearest(longint num, longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((-2 * num + den) / (2 * den));
  endfunction

  task automatic clear_stores();
    for (int i = 0; i < StoreSize; i++) begin
      colour_mem[i] = GREY_COLOR;
      depth_mem[i]  = DEPTH_MAX;
    end
  endtask

  task automatic rasterise(raster_cmd_t c);
    longint w, h, ux, uy, vx, vy, d, sgn, x0, y0, x1, y1;
    longint px, py, nb, ng, num, z;
    int     idx;
    w  = size_eff(view_w_q);
    h  = size_eff(view_h_q);
    ux = longint'(c.bx) - c.ax;
    uy = longint'(c.byc) - c.ay;
    vx = longint'(c.cx) - c.ax;
    vy = longint'(c.cy) - c.ay;
    d  = ux * vy - uy * vx;
    if (d == 0) return;
    if (cull_q && (c.az < 0 || c.bz < 0 || c.cz < 0)) return;
    sgn = (d < 0) ? -1 : 1;
    // Floor and ceiling of Q12.4 values by arithmetic shift.
    x0 = longint'(c.ax < c.bx ? (c.ax < c.cx ? c.ax : c.cx) : (c.bx < c.cx ? c.bx : c.cx));
    y0 = longint'(c.ay < c.byc ? (c.ay < c.cy ? c.ay : c.cy) : (c.byc < c.cy ? c.byc : c.cy));
    x1 = longint'(c.ax > c.bx ? (c.ax > c.cx ? c.ax : c.cx) : (c.bx > c.cx ? c.bx : c.cx));
    y1 = longint'(c.ay > c.byc ? (c.ay > c.cy ? c.ay : c.cy) : (c.byc > c.cy ? c.byc : c.cy));
    x0 = x0 >>> 4;
    y0 = y0 >>> 4;
    x1 = -((-x1) >>> 4);
    y1 = -((-y1) >>> 4);
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > w - 1) x1 = w - 1;
    if (y1 > h - 1) y1 = h - 1;
    for (longint y = y0; y < y1; y++) begin
      for (longint x = x0; x < x1; x++) begin
        if (!edge_inside(c.ax, c.ay, c.bx, c.byc, x * 16 + 8, y * 16 + 8)) continue;
        if (!edge_inside(c.bx, c.byc, c.cx, c.cy, x * 16 + 8, y * 16 + 8)) continue;
        if (!edge_inside(c.cx, c.cy, c.ax, c.ay, x * 16 + 8, y * 16 + 8)) continue;
        // Depth is taken at the pixel corner, not at its centre.
        px  = x * 16 - c.ax;
        py  = y * 16 - c.ay;
        nb  = vy * px - vx * py;
        ng  = ux * py - uy * px;
        num = nb * (longint'(c.bz) - c.az) + ng * (longint'(c.cz) - c.az);
        z   = longint'(c.az) + div_nearest(num * sgn, d * sgn);
        if (z > DEPTH_MAX) z = DEPTH_MAX;
        if (z < DEPTH_MIN) z = DEPTH_MIN;
        idx = int'((h - 1 - y) * w + x);
        if (z < depth_mem[idx]) begin
          depth_mem[idx]  = int'(z);
          colour_mem[idx] = c.color;
        end
      end
    end
  endtask

  task automatic predict_command(raster_cmd_t c);
    pixel_t p;
    longint area;
    case (c.cmd)
      CMD_CLEAR: clear_stores();
      CMD_DRAW:  rasterise(c);
      CMD_READ: begin
        area = size_eff(view_w_q) * size_eff(view_h_q);
        if (longint'(c.pidx) >= area) begin
          p.color = '0;
          p.depth = '0;
        end else begin
          p.color = colour_mem[c.pidx];
          p.depth = depth_mem[c.pidx][ZW-1:0];
        end
        pixel_q.push_back(p);
      end
      default: ;
    endcase
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  // Driver: predicts each accepted transaction, then offers the next command.
  raster_cmd_t drv_cmd;
  int          drv_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      drv_gap = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) predict_command(drv_cmd);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (drv_gap > 0) begin
          drv_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          drv_cmd = cmd_q.pop_front();
          s_axis_tuser_i  <= drv_cmd.cmd;
          s_axis_tdata_i  <= {drv_cmd.pidx, drv_cmd.color, drv_cmd.cz, drv_cmd.cy,
                              drv_cmd.cx, drv_cmd.bz, drv_cmd.byc, drv_cmd.bx,
                              drv_cmd.az, drv_cmd.ay, drv_cmd.ax};
          s_axis_tvalid_i <= 1'b1;
          drv_gap = pick_gap();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, plus a long hold-off when one is requested.
  int mon_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t e;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      mon_gap = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pixel_q.size() == 0) begin
          n_errors++;
          if (n_shown < ShownMax) begin
            n_shown++;
            $display("unexpected pixel: colour %h depth %h",
                     m_axis_tdata_o[23:0], m_axis_tdata_o[47:24]);
          end
        end else begin
          e = pixel_q.pop_front();
          if (m_axis_tdata_o[23:0] !== e.color || m_axis_tdata_o[47:24] !== e.depth) begin
            n_errors++;
            if (n_shown < ShownMax) begin
              n_shown++;
              $display("pixel differs: colour %h (exp %h) depth %h (exp %h)",
                       m_axis_tdata_o[23:0], e.color, m_axis_tdata_o[47:24], e.depth);
            end
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready_i <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        mon_gap = pick_gap();
      end
    end
  end

  int cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("triangle_raster_zbuffer: mismatch");
      $finish;
    end
  end

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_VIEW_WIDTH:  view_w_q = val;
      CFG_VIEW_HEIGHT: view_h_q = val;
      CFG_DEPTH_CULL:  cull_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_viewport(int w, int h, bit cull);
    cfg_write(CFG_VIEW_WIDTH, w[CfgDataW-1:0]);
    cfg_write(CFG_VIEW_HEIGHT, h[CfgDataW-1:0]);
    cfg_write(CFG_DEPTH_CULL, {8'd0, cull});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every command is through and the sequencer is idle again.
  task automatic wait_quiet();
    wait (cmd_q.size() == 0);
    do @(posedge clk_i);
    while (s_axis_tvalid_i || pixel_q.size() != 0 || !s_axis_tready_o);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic raster_cmd_t blank_cmd(logic [CmdW-1:0] op);
    raster_cmd_t c;
    c.cmd = op;
    c.ax = $urandom; c.ay = $urandom; c.bx = $urandom;
    c.byc = $urandom; c.cx = $urandom; c.cy = $urandom;
    c.az = $urandom; c.bz = $urandom; c.cz = $urandom;
    c.color = $urandom;
    c.pidx = $urandom;
    return c;
  endfunction

  // Triangle in pixel units, corners given as whole pixels.
  function automatic raster_cmd_t tri_px(int x0, int y0, int x1, int y1, int x2, int y2,
                                         int z, logic [RgbW-1:0] rgb);
    raster_cmd_t c;
    c = blank_cmd(CMD_DRAW);
    c.ax = x0 * 16; c.ay = y0 * 16; c.bx = x1 * 16;
    c.byc = y1 * 16; c.cx = x2 * 16; c.cy = y2 * 16;
    c.az = z; c.bz = z; c.cz = z;
    c.color = rgb;
    return c;
  endfunction

  function automatic raster_cmd_t read_at(int idx);
    raster_cmd_t c;
    c = blank_cmd(CMD_READ);
    c.pidx = idx[IdxW-1:0];
    return c;
  endfunction

  // Small triangle around a random pixel; span is its size in pixels.
  function automatic raster_cmd_t small_tri(int w, int h, int span);
    raster_cmd_t c;
    int          zb;
    c = blank_cmd(CMD_DRAW);
    last_px = $urandom_range(0, w - 1);
    last_py = $urandom_range(0, h - 1);
    c.ax  = last_px * 16 + $urandom_range(0, span * 16) - span * 4;
    c.ay  = last_py * 16 + $urandom_range(0, span * 16) - span * 4;
    c.bx  = last_px * 16 + $urandom_range(0, span * 16) - span * 4;
    c.byc = last_py * 16 + $urandom_range(0, span * 16) - span * 4;
    c.cx  = last_px * 16 + $urandom_range(0, span * 16) - span * 4;
    c.cy  = last_py * 16 + $urandom_range(0, span * 16) - span * 4;
    if ($urandom_range(0, 9) == 0) begin
      c.cx = c.ax;
      c.cy = c.ay;
    end
    if ($urandom_range(0, 5) != 0) begin
      zb   = int'($urandom_range(0, 1 << 22)) - (1 << 19);
      c.az = zb + int'($urandom_range(0, 1 << 17)) - (1 << 16);
      c.bz = zb + int'($urandom_range(0, 1 << 17)) - (1 << 16);
      c.cz = zb + int'($urandom_range(0, 1 << 17)) - (1 << 16);
    end
    return c;
  endfunction

  function automatic raster_cmd_t near_read(int w, int h);
    int x, y;
    if ($urandom_range(0, 4) == 0) return blank_cmd(CMD_READ);
    x = last_px + int'($urandom_range(0, 6)) - 3;
    y = last_py + int'($urandom_range(0, 6)) - 3;
    x = (x < 0) ? 0 : (x > w - 1 ? w - 1 : x);
    y = (y < 0) ? 0 : (y > h - 1 ? h - 1 : y);
    return read_at((h - 1 - y) * w + x);
  endfunction

  // noisy: fully random triangles are allowed, as the viewport is tiny.
  task automatic random_phase(int w, int h, bit cull, int n, bit noisy, int span);
    int ew, eh, r;
    ew = (w == 0) ? 1 : (w > 256 ? 256 : w);
    eh = (h == 0) ? 1 : (h > 256 ? 256 : h);
    set_viewport(w, h, cull);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 299);
      if (r < 2) cmd_q.push_back(blank_cmd(CMD_CLEAR));
      else if (r < 5) cmd_q.push_back(blank_cmd(2'd3));
      else if (r < 140) cmd_q.push_back(near_read(ew, eh));
      else if (noisy && r < 200) cmd_q.push_back(blank_cmd(CMD_DRAW));
      else cmd_q.push_back(small_tri(ew, eh, span));
    end
    wait_quiet();
  endtask

  initial begin
    raster_cmd_t c;
    clear_stores();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the full viewport.
    set_viewport(256, 256, 1'b0);
    cmd_q.push_back(read_at(0));
    cmd_q.push_back(read_at(65535));
    cmd_q.push_back(tri_px(2, 2, 8, 2, 2, 8, 'h10000, 24'h112233));
    cmd_q.push_back(read_at(253 * 256 + 3));
    // Same triangle wound the other way and nearer: the edge tests reject it, so the pixel keeps its colour.
    cmd_q.push_back(tri_px(2, 2, 2, 8, 8, 2, 'h08000, 24'hFFFFFF));
    cmd_q.push_back(read_at(253 * 256 + 3));
    // Farther: loses the depth test.
    cmd_q.push_back(tri_px(2, 2, 8, 2, 2, 8, 'h20000, 24'h000000));
    cmd_q.push_back(read_at(253 * 256 + 3));
    // Zero area, then an unused command.
    cmd_q.push_back(tri_px(2, 2, 4, 4, 6, 6, -'h1000, 24'hABCDEF));
    cmd_q.push_back(blank_cmd(2'd3));
    cmd_q.push_back(read_at(252 * 256 + 3));
    // Steep depth slopes: the vertex depths lie at both ends of the range.
    c = tri_px(10, 10, 14, 10, 10, 14, 0, 24'h00FF00);
    c.az = DEPTH_MIN; c.bz = DEPTH_MAX; c.cz = DEPTH_MIN;
    cmd_q.push_back(c);
    cmd_q.push_back(read_at(244 * 256 + 10));
    cmd_q.push_back(read_at(244 * 256 + 12));
    // Against the top-right corner: the last column and row stay untouched.
    cmd_q.push_back(tri_px(250, 250, 300, 250, 250, 300, 0, 24'h800001));
    cmd_q.push_back(read_at(0 * 256 + 255));
    cmd_q.push_back(read_at(1 * 256 + 254));
    cmd_q.push_back(blank_cmd(CMD_CLEAR));
    cmd_q.push_back(read_at(253 * 256 + 3));
    wait_quiet();

    // One by one pixel with culling: extremes of the coordinates.
    set_viewport(1, 1, 1'b1);
    c = blank_cmd(CMD_DRAW);
    c.ax = -32768; c.ay = -32768; c.bx = 32767; c.byc = -32768;
    c.cx = -32768; c.cy = 32767; c.az = 0; c.bz = 0; c.cz = 0;
    cmd_q.push_back(c);
    c.bz = -1;
    cmd_q.push_back(c);
    cmd_q.push_back(read_at(0));
    cmd_q.push_back(read_at(1));
    wait_quiet();

    // Register extremes: zero acts as one, values above the maximum clip.
    random_phase(511, 0, 1'b0, 30, 1'b1, 4);
    random_phase(12, 10, 1'b1, 40, 1'b1, 6);
    // Hold the result side off long enough for reads to back up the input.
    hold_cycles = 3000;
    random_phase(12, 10, 1'b1, 80, 1'b1, 6);
    random_phase(256, 256, 1'b0, 150, 1'b0, 3);
    random_phase(5, 3, 1'b0, 80, 1'b1, 4);
    random_phase(9, 200, 1'b0, 90, 1'b0, 4);
    random_phase(40, 24, 1'b1, 90, 1'b0, 5);

    repeat (100) @(posedge clk_i);
    n_errors += pixel_q.size();
    if (n_errors == 0) begin
      $display("triangle_raster_zbuffer: match");
    end else begin
      $display("triangle_raster_zbuffer: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/trz_pkg.sv
src/trz_mac.sv
src/trz_div.sv
src/triangle_raster_zbuffer.sv
tb/sv/triangle_raster_zbuffer_tb.sv
